/* design/rmst_pkg.sv */
package rmst_pkg;

    // Field widths fixed by the item format
    localparam int POS_W   = 10;
    localparam int END_W   = 11;
    localparam int VALUE_W = 31;

    // Tree shape: one leaf per position code, heap order, root at 1
    localparam int LEAF_COUNT = 1 << POS_W;
    localparam int NODE_COUNT = 2 * LEAF_COUNT;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    // Query bounds reach NODE_COUNT itself, so one bit more
    localparam int BOUND_W    = NODE_AW + 1;

    localparam logic [NODE_AW-1:0] ROOT_NODE = NODE_AW'(1);

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_QLO,
        ST_QHI
    } t_state;

    // One write port and one read port of the node store
    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        logic [VALUE_W-1:0] wdata;
        logic [NODE_AW-1:0] raddr;
    } t_ram_req;

    function automatic logic [VALUE_W-1:0] larger(input logic [VALUE_W-1:0] x,
                                                  input logic [VALUE_W-1:0] y);
        larger = (x > y) ? x : y;
    endfunction

endpackage

/* design/rmst_node_ram.sv */
module rmst_node_ram (
    input  logic                          i_clk,
    input  rmst_pkg::t_ram_req            i_req,
    output logic [rmst_pkg::VALUE_W-1:0]  o_rdata
);
    import rmst_pkg::*;

    logic [VALUE_W-1:0] r_mem [NODE_COUNT];

    // Write one node, read one node with registered data
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

/* design/range_max_segment_tree.sv */
// Range-maximum segment tree over 1024 leaves of 31-bit values, kept in one
// 2048-entry node memory with one write and one read port (registered read
// data). After reset the block sweeps the memory to zero, one node per cycle,
// holding busy high until the sweep ends. An update (opcode 0) writes the leaf
// and climbs to the root, one level per cycle, with busy high and no result. A
// query (opcode 1) walks the two range borders upward; at each level the low
// border node is read and then the high one, because both go through the single
// read port. Busy stays high for the whole walk, and the query's result appears
// on o_range_max with o_range_valid high for exactly one cycle, the cycle in
// which busy drops. The receiver cannot stall; a new item may be started in that
// same cycle.
module range_max_segment_tree (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [rmst_pkg::POS_W-1:0]    i_position,
    input  logic [rmst_pkg::VALUE_W-1:0]  i_new_value,
    input  logic [rmst_pkg::POS_W-1:0]    i_range_first,
    input  logic [rmst_pkg::END_W-1:0]    i_range_end,
    output logic                          o_range_valid,
    output logic [rmst_pkg::VALUE_W-1:0]  o_range_max
);
    import rmst_pkg::*;

    t_state             r_state,     n_state;
    logic [NODE_AW-1:0] r_clr_addr,  n_clr_addr;
    logic [NODE_AW-1:0] r_node,      n_node;
    logic [VALUE_W-1:0] r_val,       n_val;
    logic [BOUND_W-1:0] r_lo,        n_lo;
    logic [BOUND_W-1:0] r_hi,        n_hi;
    logic [VALUE_W-1:0] r_best,      n_best;
    logic               r_pend,      n_pend;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_max,   n_out_max;

    t_ram_req           ram_req;
    logic [VALUE_W-1:0] ram_rdata;

    logic [NODE_AW-1:0] leaf_addr;
    logic [NODE_AW-1:0] parent;
    logic [VALUE_W-1:0] up_max;
    logic [VALUE_W-1:0] best_now;
    logic [BOUND_W-1:0] end_clamped;
    logic [BOUND_W-1:0] hi_dec;

    rmst_node_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // Datapath helpers
    assign leaf_addr   = NODE_AW'(LEAF_COUNT) + NODE_AW'(i_position);
    assign parent      = r_node >> 1;
    assign up_max      = larger(r_val, ram_rdata);
    assign best_now    = r_pend ? larger(r_best, ram_rdata) : r_best;
    assign end_clamped = (BOUND_W'(i_range_end) > BOUND_W'(LEAF_COUNT))
                         ? BOUND_W'(LEAF_COUNT) : BOUND_W'(i_range_end);
    assign hi_dec      = r_hi - BOUND_W'(1);

    // Advance the sequencer and drive the node memory
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_node      = r_node;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_best      = r_best;
        n_pend      = r_pend;
        n_out_valid = 1'b0;
        n_out_max   = r_out_max;
        ram_req     = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};

        unique case (r_state)
            ST_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_clr_addr;
                n_clr_addr    = r_clr_addr + NODE_AW'(1);
                if (r_clr_addr == NODE_AW'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (t_opcode'(i_opcode) == OP_UPDATE) begin
                        // Write the leaf, fetch its sibling
                        ram_req.we    = 1'b1;
                        ram_req.waddr = leaf_addr;
                        ram_req.wdata = i_new_value;
                        ram_req.raddr = leaf_addr ^ NODE_AW'(1);
                        n_node        = leaf_addr;
                        n_val         = i_new_value;
                        n_state       = ST_UPD;
                    end else begin
                        n_lo    = BOUND_W'(i_range_first) + BOUND_W'(LEAF_COUNT);
                        n_hi    = end_clamped + BOUND_W'(LEAF_COUNT);
                        n_best  = '0;
                        n_pend  = 1'b0;
                        n_state = ST_QLO;
                    end
                end
            end
            ST_UPD: begin
                // Store the parent maximum, fetch the next sibling
                ram_req.we    = 1'b1;
                ram_req.waddr = parent;
                ram_req.wdata = up_max;
                ram_req.raddr = parent ^ NODE_AW'(1);
                n_node        = parent;
                n_val         = up_max;
                if (parent == ROOT_NODE) begin
                    n_state = ST_IDLE;
                end
            end
            ST_QLO: begin
                n_best = best_now;
                if (r_lo < r_hi) begin
                    n_pend  = r_lo[0];
                    ram_req.raddr = r_lo[NODE_AW-1:0];
                    if (r_lo[0]) begin
                        n_lo = r_lo + BOUND_W'(1);
                    end
                    n_state = ST_QHI;
                end else begin
                    // Borders met: deliver the item
                    n_out_valid = 1'b1;
                    n_out_max   = best_now;
                    n_pend      = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            ST_QHI: begin
                n_best = best_now;
                n_pend = r_hi[0];
                n_lo   = r_lo >> 1;
                ram_req.raddr = hi_dec[NODE_AW-1:0];
                if (r_hi[0]) begin
                    n_hi = hi_dec >> 1;
                end else begin
                    n_hi = r_hi >> 1;
                end
                n_state = ST_QLO;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_node    <= n_node;
        r_val     <= n_val;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_best    <= n_best;
        r_out_max <= n_out_max;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_range_valid = r_out_valid;
    assign o_range_max   = r_out_max;

`ifndef SYNTH
    // A result only follows the end of a query walk
    a_result_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range_valid |-> $past(r_state == ST_QLO))
        else $error("result without a finished query");

    // Queries never write the node memory
    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QLO || r_state == ST_QHI) |-> !ram_req.we)
        else $error("node write during query");

    // The update climb never runs past the root
    a_update_below_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_node > ROOT_NODE))
        else $error("update climb beyond root");

    // The clearing sweep starts at node zero right after reset
    a_clear_start: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_CLEAR && r_clr_addr == '0))
        else $error("clearing sweep did not restart");
`endif

endmodule
